[sv/ace_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ace_pkg
// Types and constants shared by the arithmetic coder encoder.
// ----------------------------------------------------------------------------
package ace_pkg;

    localparam int PRECISION = 32;

    localparam int TOTAL_W   = 17;
    localparam int CUM_LO_W  = 16;
    localparam int CUM_HI_W  = 17;
    localparam int PEND_W    = 32;

    // quotient of (range * cum) / total never exceeds 2^PRECISION
    localparam int DIV_STEPS = PRECISION + 1;
    localparam int PROD_W    = DIV_STEPS + CUM_HI_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    localparam int MAX_RES   = 33;
    localparam int RCNT_W    = $clog2(MAX_RES + 1);

    localparam logic [PRECISION-1:0] MASK    = {PRECISION{1'b1}};
    localparam logic [PRECISION-1:0] HALF    = {1'b1, {(PRECISION-1){1'b0}}};
    localparam logic [PRECISION-1:0] QUARTER = {2'b01, {(PRECISION-2){1'b0}}};

    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = TOTAL_W'(65536);
    localparam logic [PEND_W-1:0]  PEND_MAX    = {PEND_W{1'b1}};

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [2:0] ADDR_TOTAL = 3'd0;

    typedef struct packed {
        logic                command;
        logic [CUM_LO_W-1:0] cum_low;
        logic [CUM_HI_W-1:0] cum_upper;
    } t_enc_in;

    typedef struct packed {
        logic              lead_bit;
        logic [PEND_W-1:0] follow_count;
        logic              last;
    } t_enc_out;

endpackage
`default_nettype wire

[sv/arithmetic_coder_encoder_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// arithmetic_coder_encoder_core
// Integer arithmetic-coding encoder with pending underflow bits.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+----------------------
//  in        | input     | i_in_valid / o_in_ready     | i_in_data  (t_enc_in)
//  out       | output    | o_out_valid / i_out_ready   | o_out_data (t_enc_out)
//  config    | input     | psel/penable/pwrite, pready | paddr, pwdata, prdata
//
//  Encode: accept, then two passes of multiply, bit-serial restoring divide
//  and update, one pass per bound with both sharing the one divider; then one
//  renormalization step per cycle, then an end state closes the transaction.
//  Finish: emits the final code bit with its pending count, then returns to idle.
//  A stalled output holds the renormalization loop.
//  Reset is synchronous; the interval returns to [0, MASK], total to 65536.
// ----------------------------------------------------------------------------
module arithmetic_coder_encoder_core
    import ace_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_enc_in           i_in_data,

    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_enc_out               o_out_data,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_UPD,
        S_REN,
        S_END,
        S_FIN
    } t_state;

    t_state                 r_state,   n_state;
    logic [TOTAL_W-1:0]     r_total,   n_total;
    logic [PRECISION-1:0]   r_lo,      n_lo;
    logic [PRECISION-1:0]   r_hi,      n_hi;
    logic [PEND_W-1:0]      r_pend,    n_pend;
    logic [TOTAL_W-1:0]     r_t,       n_t;
    logic [CUM_HI_W-1:0]    r_ch,      n_ch;
    logic [CUM_LO_W-1:0]    r_cl,      n_cl;
    logic [DIV_STEPS-1:0]   r_rng,     n_rng;
    logic                   r_second,  n_second;
    logic [TOTAL_W-1:0]     r_rem,     n_rem;
    logic [DIV_STEPS-1:0]   r_dsh,     n_dsh;
    logic [DCNT_W-1:0]      r_dcnt,    n_dcnt;
    logic [RCNT_W-1:0]      r_rcnt,    n_rcnt;
    logic                   r_hold_valid, n_hold_valid;
    t_enc_out               r_hold,    n_hold;
    logic                   r_out_valid,  n_out_valid;
    t_enc_out               r_out,     n_out;

    logic                   w_cfg_wr;
    logic                   w_out_free;
    logic [TOTAL_W-1:0]     w_t;
    logic [CUM_HI_W-1:0]    w_ch_clip;
    logic [CUM_HI_W-1:0]    w_ch;
    logic [CUM_HI_W-1:0]    w_ch_m1;
    logic [CUM_LO_W-1:0]    w_cl;
    logic [CUM_HI_W-1:0]    w_mul_b;
    logic [PROD_W-1:0]      w_prod;
    logic [TOTAL_W:0]       w_rem_sh;
    logic [TOTAL_W:0]       w_rem_sub;
    logic                   w_qbit;
    logic [PEND_W-1:0]      w_pend_inc;
    logic                   w_below_half;
    logic                   w_above_half;
    logic                   w_middle;
    logic [PRECISION-1:0]   w_lo_q;
    logic [PRECISION-1:0]   w_hi_q;

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && (paddr[2] == ADDR_TOTAL[2]);
    assign prdata     = (paddr[2] == ADDR_TOTAL[2]) ? {(32-TOTAL_W)'(0), r_total} : 32'd0;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // operand clamps
    always_comb begin
        if (r_total == '0) begin
            w_t = TOTAL_W'(1);
        end else if (r_total > TOTAL_MAX) begin
            w_t = TOTAL_MAX;
        end else begin
            w_t = r_total;
        end
        w_ch_clip = (i_in_data.cum_upper > w_t) ? w_t : i_in_data.cum_upper;
        w_ch      = (w_ch_clip == '0) ? CUM_HI_W'(1) : w_ch_clip;
        w_ch_m1   = w_ch - CUM_HI_W'(1);
        w_cl      = ({1'b0, i_in_data.cum_low} > w_ch_m1) ? w_ch_m1[CUM_LO_W-1:0]
                                                          : i_in_data.cum_low;
    end

    // shared multiplier and divider step
    assign w_mul_b   = r_second ? {1'b0, r_cl} : r_ch;
    assign w_prod    = PROD_W'(r_rng) * PROD_W'(w_mul_b);
    assign w_rem_sh  = {r_rem, r_dsh[DIV_STEPS-1]};
    assign w_qbit    = (w_rem_sh >= {1'b0, r_t});
    assign w_rem_sub = w_qbit ? (w_rem_sh - {1'b0, r_t}) : w_rem_sh;

    assign w_pend_inc   = (r_pend == PEND_MAX) ? r_pend : r_pend + PEND_W'(1);
    assign w_below_half = !r_hi[PRECISION-1];
    assign w_above_half = r_lo[PRECISION-1];
    assign w_middle     = (r_lo[PRECISION-1:PRECISION-2] == 2'b01)
                       && (r_hi[PRECISION-1:PRECISION-2] == 2'b10);
    assign w_lo_q       = r_lo - QUARTER;
    assign w_hi_q       = r_hi - QUARTER;

    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_pend       = r_pend;
        n_t          = r_t;
        n_ch         = r_ch;
        n_cl         = r_cl;
        n_rng        = r_rng;
        n_second     = r_second;
        n_rem        = r_rem;
        n_dsh        = r_dsh;
        n_dcnt       = r_dcnt;
        n_rcnt       = r_rcnt;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;

        if (w_cfg_wr) begin
            n_total = pwdata[TOTAL_W-1:0];
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.command == CMD_FINISH) begin
                        n_state = S_FIN;
                    end else begin
                        n_t      = w_t;
                        n_ch     = w_ch;
                        n_cl     = w_cl;
                        n_rng    = {1'b0, r_hi} - {1'b0, r_lo} + DIV_STEPS'(1);
                        n_second = 1'b0;
                        n_rcnt   = '0;
                        n_state  = S_MUL;
                    end
                end
            end
            S_MUL: begin
                // top bits of the product are below the divisor
                n_rem   = w_prod[PROD_W-1 -: TOTAL_W];
                n_dsh   = w_prod[DIV_STEPS-1:0];
                n_dcnt  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem  = w_rem_sub[TOTAL_W-1:0];
                n_dsh  = {r_dsh[DIV_STEPS-2:0], w_qbit};
                n_dcnt = r_dcnt + DCNT_W'(1);
                if (r_dcnt == DCNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (!r_second) begin
                    n_hi     = r_lo + r_dsh[PRECISION-1:0] - PRECISION'(1);
                    n_second = 1'b1;
                    n_state  = S_MUL;
                end else begin
                    n_lo    = r_lo + r_dsh[PRECISION-1:0];
                    n_state = S_REN;
                end
            end
            S_REN: begin
                if (w_below_half || w_above_half) begin
                    // hold the decided bit until its successor shows whether it is last
                    if (!r_hold_valid || w_out_free) begin
                        if (r_hold_valid) begin
                            n_out       = r_hold;
                            n_out_valid = 1'b1;
                        end
                        n_hold_valid          = 1'b1;
                        n_hold.lead_bit       = w_above_half;
                        n_hold.follow_count   = r_pend;
                        n_hold.last           = 1'b0;
                        n_pend                = '0;
                        n_lo                  = {r_lo[PRECISION-2:0], 1'b0};
                        n_hi                  = {r_hi[PRECISION-2:0], 1'b1};
                        n_rcnt                = r_rcnt + RCNT_W'(1);
                        if (r_rcnt == RCNT_W'(MAX_RES - 1)) begin
                            n_state = S_END;
                        end
                    end
                end else if (w_middle) begin
                    n_pend = w_pend_inc;
                    n_lo   = {w_lo_q[PRECISION-2:0], 1'b0};
                    n_hi   = {w_hi_q[PRECISION-2:0], 1'b1};
                end else begin
                    n_state = S_END;
                end
            end
            S_END: begin
                if (!r_hold_valid) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out        = r_hold;
                    n_out.last   = 1'b1;
                    n_out_valid  = 1'b1;
                    n_hold_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out.lead_bit     = (r_lo >= QUARTER);
                    n_out.follow_count = w_pend_inc;
                    n_out.last         = 1'b1;
                    n_out_valid        = 1'b1;
                    n_lo               = '0;
                    n_hi               = MASK;
                    n_pend             = '0;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_total      <= TOTAL_MAX;
            r_lo         <= '0;
            r_hi         <= MASK;
            r_pend       <= '0;
            r_second     <= 1'b0;
            r_dcnt       <= '0;
            r_rcnt       <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_total      <= n_total;
            r_lo         <= n_lo;
            r_hi         <= n_hi;
            r_pend       <= n_pend;
            r_second     <= n_second;
            r_dcnt       <= n_dcnt;
            r_rcnt       <= n_rcnt;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
        r_t    <= n_t;
        r_ch   <= n_ch;
        r_cl   <= n_cl;
        r_rng  <= n_rng;
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_hold <= n_hold;
        r_out  <= n_out;
    end

`ifndef SYNTHESIS
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_valid)
        else $error("held result left behind when returning to idle");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_t))
        else $error("divider remainder not below divisor");

    a_result_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcnt <= RCNT_W'(MAX_RES))
        else $error("too many results for one transaction");

    a_interval_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_lo <= r_hi))
        else $error("coding interval inverted");
`endif

endmodule
`default_nettype wire

[sim/ace_code_checker.sv]
// ----------------------------------------------------------------------------
// ace_code_checker
// Watches the symbol, code-bit and register channels of the arithmetic coder
// encoder, keeps its own copy of the coding interval, and compares every
// code-bit transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module ace_code_checker
    import ace_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire t_enc_in     i_in_data,

    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire t_enc_out    i_out_data,

    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic [31:0] i_prdata,
    input  wire logic        i_pready,

    output int               o_err_count,
    output int               o_results_due
);

    localparam logic [PRECISION-1:0] UPPER_QTR = HALF | QUARTER;

    logic [TOTAL_W-1:0]   freq_total    = TOTAL_MAX;
    logic [PRECISION-1:0] code_low      = '0;
    logic [PRECISION-1:0] code_high     = MASK;
    logic [PEND_W-1:0]    underflow_cnt = '0;

    t_enc_out expected_codes[$];
    int       err_total   = 0;
    int       decided_cnt = 0;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_total++;
    endtask

    function automatic void add_underflow();
        if (underflow_cnt != PEND_MAX) begin
            underflow_cnt++;
        end
    endfunction

    // Queue one decided bit with the opposite bits owed behind it.
    function automatic void decide_bit(input logic bit_val);
        t_enc_out res;
        res.lead_bit     = bit_val;
        res.follow_count = underflow_cnt;
        res.last         = 1'b0;
        expected_codes = {expected_codes, res};
        underflow_cnt = '0;
        decided_cnt++;
    endfunction

    function automatic void predict_codes(input t_enc_in item);
        logic [63:0] tot;
        logic [63:0] ch;
        logic [63:0] cl;
        logic [63:0] rng;
        logic [63:0] lo;
        logic [63:0] hi;
        int          k;

        decided_cnt = 0;
        if (item.command == CMD_FINISH) begin
            add_underflow();
            decide_bit((code_low < QUARTER) ? 1'b0 : 1'b1);
            expected_codes[expected_codes.size()-1].last = 1'b1;
            code_low      = '0;
            code_high     = MASK;
            underflow_cnt = '0;
            return;
        end

        tot = 64'(freq_total);
        ch  = 64'(item.cum_upper);
        cl  = 64'(item.cum_low);
        if (tot == 0) tot = 1;
        if (tot > 64'(TOTAL_MAX)) tot = 64'(TOTAL_MAX);
        if (ch > tot) ch = tot;
        if (ch == 0) ch = 1;
        if (cl > ch - 1) cl = ch - 1;

        lo  = 64'(code_low);
        hi  = 64'(code_high);
        rng = hi - lo + 1;
        hi  = lo + (rng * ch) / tot - 1;
        lo  = lo + (rng * cl) / tot;
        code_high = hi[PRECISION-1:0];
        code_low  = lo[PRECISION-1:0];

        // each pass doubles the interval width, so the guard never binds
        for (k = 0; k < 4 * PRECISION; k++) begin
            if (code_high < HALF) begin
                decide_bit(1'b0);
            end else if (code_low >= HALF) begin
                decide_bit(1'b1);
                code_low  = code_low - HALF;
                code_high = code_high - HALF;
            end else if (code_low >= QUARTER && code_high < UPPER_QTR) begin
                add_underflow();
                code_low  = code_low - QUARTER;
                code_high = code_high - QUARTER;
            end else begin
                break;
            end
            code_low  = {code_low[PRECISION-2:0], 1'b0};
            code_high = {code_high[PRECISION-2:0], 1'b1};
            if (decided_cnt >= MAX_RES) break;
        end

        if (decided_cnt > 0) begin
            expected_codes[expected_codes.size()-1].last = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_enc_out want;
        if (!i_rst_n) begin
            freq_total    = TOTAL_MAX;
            code_low      = '0;
            code_high     = MASK;
            underflow_cnt = '0;
            expected_codes.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch($sformatf("unexpected code bit %0d follow %0d last %0d",
                        i_out_data.lead_bit, i_out_data.follow_count, i_out_data.last));
                end else begin
                    want = expected_codes.pop_front();
                    if (i_out_data.lead_bit !== want.lead_bit) begin
                        report_mismatch($sformatf("lead_bit got %0d want %0d",
                            i_out_data.lead_bit, want.lead_bit));
                    end
                    if (i_out_data.follow_count !== want.follow_count) begin
                        report_mismatch($sformatf("follow_count got %0d want %0d",
                            i_out_data.follow_count, want.follow_count));
                    end
                    if (i_out_data.last !== want.last) begin
                        report_mismatch($sformatf("last got %0d want %0d",
                            i_out_data.last, want.last));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_codes(i_in_data);
            end
            if (i_psel && i_penable && i_pready && i_paddr == ADDR_TOTAL) begin
                if (i_pwrite) begin
                    freq_total = i_pwdata[TOTAL_W-1:0];
                end else if (i_prdata !== 32'(freq_total)) begin
                    report_mismatch($sformatf("frequency_total read %0d want %0d",
                        i_prdata, freq_total));
                end
            end
        end
        o_err_count   = err_total;
        o_results_due = expected_codes.size();
    end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives symbols, finish commands and frequency totals into the arithmetic
// coder encoder with random gaps and back-pressure; the checker beside the
// block predicts every code bit and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import ace_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 160;
    localparam int HOLD_CYCLES  = 500;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_enc_in     i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_enc_out    o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int                 err_count;
    int                 results_due;
    int                 watch_cycles;
    logic               idle_on;
    logic               hold_req;
    logic [TOTAL_W-1:0] cur_total;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    arithmetic_coder_encoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    ace_code_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out_data    (o_out_data),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .o_err_count   (err_count),
        .o_results_due (results_due)
    );

    function automatic int effective_total();
        if (cur_total == 0) return 1;
        if (cur_total > TOTAL_MAX) return int'(TOTAL_MAX);
        return int'(cur_total);
    endfunction

    // Mostly well-formed symbols: narrow ones for long bit runs, middle ones
    // for underflow, the rest spread; some finishes and raw noise mixed in.
    function automatic t_enc_in make_symbol(input int eff);
        t_enc_in item;
        int      pick;
        int      ch;
        int      cl;
        int      span;
        pick           = $urandom_range(0, 99);
        item.command   = CMD_ENCODE;
        item.cum_low   = 16'($urandom);
        item.cum_upper = 17'($urandom);
        if (pick < 8) begin
            item.command = CMD_FINISH;
        end else if (pick >= 18) begin
            ch = $urandom_range(1, eff);
            if (pick < 35) begin
                span = (ch < 4) ? ch : 4;
                cl   = ch - $urandom_range(1, span);
            end else if (pick < 50 && eff >= 16) begin
                cl = eff * 3 / 8 + $urandom_range(0, eff / 16);
                ch = eff * 5 / 8 - $urandom_range(0, eff / 16);
            end else begin
                cl = $urandom_range(0, ch - 1);
            end
            item.cum_low   = 16'(cl);
            item.cum_upper = 17'(ch);
        end
        return item;
    endfunction

    // Offer one transaction; returns at the falling edge after acceptance.
    task automatic send_item(input t_enc_in item);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_fields(input logic cmd, input int cl, input int ch);
        t_enc_in item;
        item.command   = cmd;
        item.cum_low   = 16'(cl);
        item.cum_upper = 17'(ch);
        send_item(item);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_TOTAL;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_total(input logic [31:0] value);
        apb_access(1'b1, value);
        cur_total = value[TOTAL_W-1:0];
        apb_access(1'b0, '0);
    endtask

    // Hold off until every predicted code bit is out and the core has
    // finished any symbol that decides no bit.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (results_due != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_phase(input int count, input int quiet_tail);
        int k;
        for (k = 0; k < count; k++) begin
            if (k == count - quiet_tail) idle_on = 1'b0;
            send_item(make_symbol(effective_total()));
        end
    endtask

    initial begin : result_sink
        int stall_cycles;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                for (stall_cycles = 0; stall_cycles < HOLD_CYCLES; stall_cycles++) begin
                    @(negedge i_clk);
                end
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        for (watch_cycles = 0; watch_cycles < LIMIT_CYCLES; watch_cycles++) begin
            @(posedge i_clk);
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        idle_on    = 1'b1;
        hold_req   = 1'b0;
        cur_total  = TOTAL_MAX;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        apb_access(1'b0, '0);

        // full-width symbol, edge symbols, empty, inverted and oversized bounds
        send_fields(CMD_ENCODE, 0, 65536);
        send_fields(CMD_ENCODE, 0, 1);
        send_fields(CMD_ENCODE, 65535, 65536);
        send_fields(CMD_ENCODE, 32768, 32769);
        send_fields(CMD_FINISH, 65535, 131071);
        send_fields(CMD_ENCODE, 0, 0);
        send_fields(CMD_ENCODE, 500, 500);
        send_fields(CMD_ENCODE, 65535, 3);
        send_fields(CMD_ENCODE, 65535, 131071);
        // middle symbols build up underflow bits
        repeat (3) send_fields(CMD_ENCODE, 24576, 40960);
        send_fields(CMD_ENCODE, 0, 30000);
        send_fields(CMD_FINISH, 0, 0);
        send_fields(CMD_FINISH, 0, 0);

        drain();
        set_total(32'd1);
        send_fields(CMD_ENCODE, 0, 1);
        send_fields(CMD_ENCODE, 7, 65536);

        drain();
        set_total(32'd0);
        send_fields(CMD_ENCODE, 0, 0);
        send_fields(CMD_ENCODE, 1, 2);

        drain();
        set_total(32'd100000);
        send_fields(CMD_ENCODE, 40000, 70000);

        drain();
        set_total(32'hFFFF_FFFF);
        send_fields(CMD_ENCODE, 65535, 65536);
        send_fields(CMD_FINISH, 0, 0);

        drain();
        set_total(32'd65536);
        random_phase(35, 0);

        drain();
        set_total({15'($urandom), 17'($urandom_range(2, 65535))});
        // stall the sink long enough for the core to back up its input
        hold_req = 1'b1;
        random_phase(35, 0);

        drain();
        set_total(32'($urandom_range(2, 300)));
        random_phase(40, 25);

        drain();
        if (err_count == 0 && results_due == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[sim.f]
sv/ace_pkg.sv
sv/arithmetic_coder_encoder_core.sv
sim/ace_code_checker.sv
sim/tb_top.sv
